FILE: hdl/vfcl_pkg.sv
// Shared widths, constants, register indexes and pipeline word types
// for the far-clamped volume cull and level-of-detail block. No dependencies.
package vfcl_pkg;

  localparam int POS_W     = 48;
  localparam int RAD_W     = 40;
  localparam int FWD_W     = 16;
  localparam int CEN_W     = 20;
  localparam int STEP_W    = 6;
  localparam int TAN_W     = 16;
  localparam int HSH_W     = 13;
  localparam int CFG_W     = 16;
  localparam int IDX_W     = 2;
  localparam int K_W       = 5;
  localparam int SMAG_W    = 30;
  localparam int SQP_W     = 2 * SMAG_W;
  localparam int SQ_W      = 62;
  localparam int SQ_ROOT_W = 31;
  localparam int SHELL_W   = 19;
  localparam int PC_W      = SMAG_W + SHELL_W;
  localparam int DV_NUM_W  = RAD_W + SHELL_W;
  localparam int DV_DEN_W  = SQ_ROOT_W;
  localparam int DV_Q_W    = 40;
  localparam int LONG_LAT  = SQ_ROOT_W + DV_Q_W;
  localparam int Z_W       = 38;
  localparam int FD_NUM_W  = 64;
  localparam int FD_DEN_W  = 53;
  localparam int FD_Q_W    = 6;

  localparam logic [SHELL_W-1:0] SHELL    = 19'd384000;
  localparam logic [SQ_W-1:0]    SHELL_SQ = 62'd147456000000;

  typedef enum logic [IDX_W-1:0] {
    REG_BASE = 2'd0,
    REG_TAN  = 2'd1,
    REG_HSH  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][CEN_W-1:0] rel;
    logic [2:0]            neg;
    logic [K_W-1:0]        k;
    logic [RAD_W-1:0]      r;
    logic [2:0][FWD_W-1:0] fwd;
    logic                  clamp;
    logic [2:0][PC_W-1:0]  pc;
    logic [DV_NUM_W-1:0]   pr;
  } lane_t;

  typedef struct packed {
    logic                  full;
    logic                  cull;
    logic                  ge;
    logic [2:0][CEN_W-1:0] cen;
    logic [RAD_W-1:0]      r;
  } tail_t;

endpackage

FILE: hdl/volume_far_clamp_cull_lod.sv
// Throughput: one word per cycle unless a valid output word is stalled;
// the 31-stage square root and the 40-stage shell dividers are fully
// pipelined, as is the 6-stage step divider.
// Reset: synchronous; clears all valid bits and loads base_step_count 16,
// fov_tangent 4096, half_screen_height 540.
// Depends on vfcl_pkg, vfcl_sqrt and vfcl_div.
module volume_far_clamp_cull_lod (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [vfcl_pkg::IDX_W-1:0]           cfg_index,
  input  logic [vfcl_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [vfcl_pkg::POS_W-1:0]    object_x,
  input  logic signed [vfcl_pkg::POS_W-1:0]    object_y,
  input  logic signed [vfcl_pkg::POS_W-1:0]    object_z,
  input  logic [vfcl_pkg::RAD_W-1:0]           object_radius,
  input  logic signed [vfcl_pkg::POS_W-1:0]    camera_x,
  input  logic signed [vfcl_pkg::POS_W-1:0]    camera_y,
  input  logic signed [vfcl_pkg::POS_W-1:0]    camera_z,
  input  logic signed [vfcl_pkg::FWD_W-1:0]    forward_x,
  input  logic signed [vfcl_pkg::FWD_W-1:0]    forward_y,
  input  logic signed [vfcl_pkg::FWD_W-1:0]    forward_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 draw,
  output logic                                 fullscreen,
  output logic [vfcl_pkg::STEP_W-1:0]          step_count,
  output logic signed [vfcl_pkg::CEN_W-1:0]    centre_x,
  output logic signed [vfcl_pkg::CEN_W-1:0]    centre_y,
  output logic signed [vfcl_pkg::CEN_W-1:0]    centre_z,
  output logic [vfcl_pkg::RAD_W-1:0]           drawn_radius
);

  localparam int PW    = vfcl_pkg::POS_W;
  localparam int CW    = vfcl_pkg::CEN_W;
  localparam int RW    = vfcl_pkg::RAD_W;
  localparam int FW    = vfcl_pkg::FWD_W;
  localparam int SW    = vfcl_pkg::STEP_W;
  localparam int KW    = vfcl_pkg::K_W;
  localparam int MW    = vfcl_pkg::SMAG_W;
  localparam int ZPW   = CW + FW;
  localparam int ZW    = vfcl_pkg::Z_W;
  localparam int CMPW  = 50;
  localparam int RCW   = 25;
  localparam int NEARW = 49;
  localparam int FARW  = 45;
  localparam int RHW   = 37;
  localparam int BRW   = 36;
  localparam int FNW   = vfcl_pkg::FD_NUM_W;
  localparam int FDW   = vfcl_pkg::FD_DEN_W;
  localparam int FQW   = vfcl_pkg::FD_Q_W;
  localparam int LL    = vfcl_pkg::LONG_LAT;
  localparam int HBW   = 6;

  localparam logic [RCW-1:0]         RC_CAP  = 25'h1000000;
  localparam logic [NEARW-1:0]       NEAR_B  = 49'd150994944;
  localparam logic signed [CMPW-1:0] FAR_LIM = 50'sd155189248000;
  localparam logic [SW-1:0]          MIN_STEPS = 6'd6;

  // configuration
  logic [SW-1:0]              base;
  logic [vfcl_pkg::TAN_W-1:0] tan;
  logic [vfcl_pkg::HSH_W-1:0] hsh;
  logic [vfcl_pkg::TAN_W-1:0] tsel;

  logic en;

  // stage 1
  logic [PW:0]            rel_w [3];
  logic [PW:0]            abs_w [3];
  logic                   s1_v;
  logic [2:0][PW-1:0]     s1_mag;
  logic [2:0]             s1_neg;
  logic [2:0][CW-1:0]     s1_rel;
  logic [RW-1:0]          s1_r;
  logic [2:0][FW-1:0]     s1_fwd;

  // stage 2
  logic [PW-1:0]          m_w;
  logic                   s2_v;
  logic [PW-1:0]          s2_m;
  logic [2:0][PW-1:0]     s2_mag;
  logic [2:0]             s2_neg;
  logic [2:0][CW-1:0]     s2_rel;
  logic [RW-1:0]          s2_r;
  logic [2:0][FW-1:0]     s2_fwd;

  // stage 3
  logic [HBW-1:0]         hb_w;
  logic [KW-1:0]          k_w;
  logic                   s3_v;
  logic [KW-1:0]          s3_k;
  logic [2:0][MW-1:0]     s3_smag;
  logic [2:0]             s3_neg;
  logic [2:0][CW-1:0]     s3_rel;
  logic [RW-1:0]          s3_r;
  logic [2:0][FW-1:0]     s3_fwd;

  // stage 4
  logic                                 s4_v;
  logic [2:0][vfcl_pkg::SQP_W-1:0]      s4_sqp;
  logic [2:0][vfcl_pkg::PC_W-1:0]       s4_pc;
  logic [vfcl_pkg::DV_NUM_W-1:0]        s4_pr;
  logic [KW-1:0]                        s4_k;
  logic [2:0]                           s4_neg;
  logic [2:0][CW-1:0]                   s4_rel;
  logic [RW-1:0]                        s4_r;
  logic [2:0][FW-1:0]                   s4_fwd;

  // stage 5
  logic [vfcl_pkg::SQ_W-1:0] sq_w;
  logic                      s5_v;
  logic [vfcl_pkg::SQ_W-1:0] s5_sq;
  vfcl_pkg::lane_t           s5_lane;

  // square root and shell division
  vfcl_pkg::lane_t                  ln [LL];
  logic [LL-1:0]                    lv;
  logic [vfcl_pkg::SQ_ROOT_W-1:0]   root;
  logic [vfcl_pkg::DV_Q_W-1:0]      q_c [3];
  logic [vfcl_pkg::DV_Q_W-1:0]      q_r;
  vfcl_pkg::lane_t                  lo;

  // post stages
  logic [CW-1:0]          qc_w [3];
  logic                   p1_v;
  logic [2:0][CW-1:0]     p1_cen;
  logic [2:0][FW-1:0]     p1_fwd;
  logic [RW-1:0]          p1_r;

  logic                   p2_v;
  logic signed [ZPW-1:0]  p2_zp [3];
  logic [RCW-1:0]         p2_rc;
  logic [2:0][CW-1:0]     p2_cen;
  logic [RW-1:0]          p2_r;

  logic [NEARW-1:0]       na_w;
  logic                   p3_v;
  logic signed [ZW-1:0]   p3_z;
  logic [NEARW-1:0]       p3_near;
  logic [FARW-1:0]        p3_far;
  logic [2:0][CW-1:0]     p3_cen;
  logic [RW-1:0]          p3_r;

  logic signed [CMPW-1:0] zx_w;
  logic signed [CMPW-1:0] z100_w;
  logic signed [CMPW-1:0] z10_w;
  logic                   full_w;
  logic                   p4_v;
  logic                   p4_full;
  logic [RHW-1:0]         p4_rh;
  logic [FDW-1:0]         p4_zt;
  logic [BRW-1:0]         p4_br;
  logic [2:0][CW-1:0]     p4_cen;
  logic [RW-1:0]          p4_r;

  logic [FNW-1:0]         lhs_w;
  logic [FNW-1:0]         rhs_w;
  logic                   p5_v;
  vfcl_pkg::tail_t        p5_tl;
  logic [FNW-1:0]         p5_num;
  logic [FDW-1:0]         p5_den;

  // step divider
  logic [FQW-1:0]         fd_v;
  vfcl_pkg::tail_t        fd_tl  [FQW];
  logic [FNW-1:0]         fd_rem [FQW];
  logic [FDW-1:0]         fd_den [FQW];
  logic [FQW-1:0]         fd_q   [FQW];

  logic [SW-1:0]          sel_w;
  logic [SW-1:0]          steps_w;
  vfcl_pkg::tail_t        tl;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign tsel     = (tan == '0) ? vfcl_pkg::TAN_W'(1) : tan;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= 6'd16;
      tan  <= 16'd4096;
      hsh  <= 13'd540;
    end else if (cfg_write) begin
      case (vfcl_pkg::reg_idx_t'(cfg_index))
        vfcl_pkg::REG_BASE: base <= cfg_data[SW-1:0];
        vfcl_pkg::REG_TAN:  tan  <= cfg_data[vfcl_pkg::TAN_W-1:0];
        vfcl_pkg::REG_HSH:  hsh  <= cfg_data[vfcl_pkg::HSH_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      s5_v      <= 1'b0;
      lv        <= '0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      p3_v      <= 1'b0;
      p4_v      <= 1'b0;
      p5_v      <= 1'b0;
      fd_v      <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      s5_v      <= s4_v;
      lv        <= {lv[LL-2:0], s5_v};
      p1_v      <= lv[LL-1];
      p2_v      <= p1_v;
      p3_v      <= p2_v;
      p4_v      <= p3_v;
      p5_v      <= p4_v;
      fd_v      <= {fd_v[FQW-2:0], p5_v};
      out_valid <= fd_v[FQW-1];
    end
  end

  // relative centre and magnitudes
  always_comb begin
    rel_w[0] = {object_x[PW-1], object_x} - {camera_x[PW-1], camera_x};
    rel_w[1] = {object_y[PW-1], object_y} - {camera_y[PW-1], camera_y};
    rel_w[2] = {object_z[PW-1], object_z} - {camera_z[PW-1], camera_z};
    for (int i = 0; i < 3; i++) begin
      abs_w[i] = rel_w[i][PW] ? (~rel_w[i] + 1'b1) : rel_w[i];
    end
  end

  always_comb begin
    m_w = s1_mag[0];
    if (s1_mag[1] > m_w) m_w = s1_mag[1];
    if (s1_mag[2] > m_w) m_w = s1_mag[2];
  end

  always_comb begin
    hb_w = '0;
    for (int i = 0; i < PW; i++) begin
      if (s2_m[i]) hb_w = HBW'(i);
    end
    k_w = (hb_w > HBW'(MW - 1)) ? KW'(hb_w - HBW'(MW - 1)) : '0;
  end

  always_comb begin
    sq_w = vfcl_pkg::SQ_W'(s4_sqp[0]) + vfcl_pkg::SQ_W'(s4_sqp[1])
         + vfcl_pkg::SQ_W'(s4_sqp[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag[i] <= abs_w[i][PW-1:0];
        s1_neg[i] <= rel_w[i][PW];
        s1_rel[i] <= rel_w[i][CW-1:0];
      end
      s1_r      <= object_radius;
      s1_fwd[0] <= forward_x;
      s1_fwd[1] <= forward_y;
      s1_fwd[2] <= forward_z;

      s2_m   <= m_w;
      s2_mag <= s1_mag;
      s2_neg <= s1_neg;
      s2_rel <= s1_rel;
      s2_r   <= s1_r;
      s2_fwd <= s1_fwd;

      s3_k <= k_w;
      for (int i = 0; i < 3; i++) begin
        s3_smag[i] <= MW'(s2_mag[i] >> k_w);
      end
      s3_neg <= s2_neg;
      s3_rel <= s2_rel;
      s3_r   <= s2_r;
      s3_fwd <= s2_fwd;

      for (int i = 0; i < 3; i++) begin
        s4_sqp[i] <= vfcl_pkg::SQP_W'(s3_smag[i]) * vfcl_pkg::SQP_W'(s3_smag[i]);
        s4_pc[i]  <= vfcl_pkg::PC_W'(s3_smag[i]) * vfcl_pkg::PC_W'(vfcl_pkg::SHELL);
      end
      s4_pr  <= vfcl_pkg::DV_NUM_W'(s3_r) * vfcl_pkg::DV_NUM_W'(vfcl_pkg::SHELL);
      s4_k   <= s3_k;
      s4_neg <= s3_neg;
      s4_rel <= s3_rel;
      s4_r   <= s3_r;
      s4_fwd <= s3_fwd;

      s5_sq         <= sq_w;
      s5_lane.clamp <= (s4_k != '0) || (sq_w > vfcl_pkg::SHELL_SQ);
      s5_lane.rel   <= s4_rel;
      s5_lane.neg   <= s4_neg;
      s5_lane.k     <= s4_k;
      s5_lane.r     <= s4_r;
      s5_lane.fwd   <= s4_fwd;
      s5_lane.pc    <= s4_pc;
      s5_lane.pr    <= s4_pr;

      ln[0] <= s5_lane;
      for (int i = 1; i < LL; i++) begin
        ln[i] <= ln[i-1];
      end
    end
  end

  vfcl_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (s5_sq),
    .root (root)
  );

  for (genvar g = 0; g < 3; g++) begin : g_cdiv
    vfcl_div u_div (
      .clk (clk),
      .en  (en),
      .num (vfcl_pkg::DV_NUM_W'(ln[vfcl_pkg::SQ_ROOT_W-1].pc[g])),
      .den (root),
      .quo (q_c[g])
    );
  end

  vfcl_div u_rdiv (
    .clk (clk),
    .en  (en),
    .num (ln[vfcl_pkg::SQ_ROOT_W-1].pr),
    .den (root),
    .quo (q_r)
  );

  assign lo = ln[LL-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc_w[i] = lo.neg[i] ? CW'(~q_c[i][CW-1:0] + 1'b1) : q_c[i][CW-1:0];
    end
  end

  // depth and fullscreen tests
  always_comb begin
    na_w   = {NEARW'(p2_rc) * NEARW'(273)} << 15;
    zx_w   = CMPW'(p3_z);
    z100_w = (zx_w <<< 6) + (zx_w <<< 5) + (zx_w <<< 2);
    z10_w  = (zx_w <<< 3) + (zx_w <<< 1);
    full_w = (z100_w < $signed({1'b0, p3_near}))
          || ((z10_w + $signed(CMPW'(p3_far))) >= FAR_LIM);
  end

  always_comb begin
    lhs_w = {RHW'(p4_rh * RHW'(10)), 27'b0};
    rhs_w = FNW'(p4_zt) * FNW'(6);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_cen[i] <= lo.clamp ? qc_w[i] : lo.rel[i];
      end
      p1_fwd <= lo.fwd;
      p1_r   <= lo.clamp ? RW'(q_r >> lo.k) : lo.r;

      for (int i = 0; i < 3; i++) begin
        p2_zp[i] <= $signed(p1_cen[i]) * $signed(p1_fwd[i]);
      end
      p2_rc  <= (p1_r > RW'(RC_CAP)) ? RC_CAP : p1_r[RCW-1:0];
      p2_cen <= p1_cen;
      p2_r   <= p1_r;

      p3_z    <= ZW'(p2_zp[0]) + ZW'(p2_zp[1]) + ZW'(p2_zp[2]);
      p3_near <= (na_w > NEAR_B) ? na_w : NEAR_B;
      p3_far  <= (FARW'(p2_rc) * FARW'(26)) << 15;
      p3_cen  <= p2_cen;
      p3_r    <= p2_r;

      p4_full <= full_w;
      p4_rh   <= RHW'(p3_r[RHW-1:0] * RHW'(hsh));
      p4_zt   <= FDW'(p3_z[ZW-2:0]) * FDW'(tsel);
      p4_br   <= BRW'(p3_r[BRW-1:0] * BRW'(base));
      p4_cen  <= p3_cen;
      p4_r    <= p3_r;

      p5_tl.full <= p4_full;
      p5_tl.cull <= lhs_w < rhs_w;
      p5_tl.ge   <= {p4_r[BRW-1:0], 28'b0} >= FNW'(p4_zt);
      p5_tl.cen  <= p4_cen;
      p5_tl.r    <= p4_r;
      p5_num     <= {p4_br, 28'b0};
      p5_den     <= p4_zt;
    end
  end

  // step count divider
  for (genvar s = 0; s < FQW; s++) begin : g_fd
    localparam int B = FQW - 1 - s;
    logic [FNW-1:0]  rem_in;
    logic [FDW-1:0]  den_in;
    logic [FQW-1:0]  q_in;
    vfcl_pkg::tail_t tl_in;
    logic [FNW-1:0]  dsh;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_in = p5_num;
      assign den_in = p5_den;
      assign q_in   = '0;
      assign tl_in  = p5_tl;
    end else begin : g_rest
      assign rem_in = fd_rem[s-1];
      assign den_in = fd_den[s-1];
      assign q_in   = fd_q[s-1];
      assign tl_in  = fd_tl[s-1];
    end

    assign dsh = FNW'(den_in) << B;
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        fd_den[s] <= den_in;
        fd_tl[s]  <= tl_in;
        if (ge) begin
          fd_rem[s] <= rem_in - dsh;
          fd_q[s]   <= q_in | (FQW'(1) << B);
        end else begin
          fd_rem[s] <= rem_in;
          fd_q[s]   <= q_in;
        end
      end
    end
  end

  assign tl = fd_tl[FQW-1];

  always_comb begin
    sel_w = tl.ge ? base : fd_q[FQW-1];
    if (sel_w < MIN_STEPS) sel_w = MIN_STEPS;
    if (tl.full) begin
      steps_w = base;
    end else if (tl.cull) begin
      steps_w = '0;
    end else begin
      steps_w = sel_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      draw         <= tl.full || !tl.cull;
      fullscreen   <= tl.full;
      step_count   <= steps_w;
      centre_x     <= tl.cen[0];
      centre_y     <= tl.cen[1];
      centre_z     <= tl.cen[2];
      drawn_radius <= tl.r;
    end
  end

endmodule

FILE: hdl/vfcl_sqrt.sv
// Pipelined floor square root, one root bit per stage.
// Depends on vfcl_pkg for widths.
module vfcl_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [vfcl_pkg::SQ_W-1:0]      x,
  output logic [vfcl_pkg::SQ_ROOT_W-1:0] root
);

  localparam int W  = vfcl_pkg::SQ_W;
  localparam int R  = vfcl_pkg::SQ_ROOT_W;
  localparam int TW = 64;

  logic [W-1:0] rem_q  [R];
  logic [R-1:0] root_q [R];

  for (genvar s = 0; s < R; s++) begin : g_stage
    localparam int B = R - 1 - s;
    logic [W-1:0]  rem_in;
    logic [R-1:0]  root_in;
    logic [TW-1:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in  = x;
      assign root_in = '0;
    end else begin : g_rest
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
    assign ge    = TW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        if (ge) begin
          rem_q[s]  <= rem_in - trial[W-1:0];
          root_q[s] <= root_in | (R'(1) << B);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign root = root_q[R-1];

endmodule

FILE: hdl/vfcl_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vfcl_pkg for widths.
module vfcl_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [vfcl_pkg::DV_NUM_W-1:0] num,
  input  logic [vfcl_pkg::DV_DEN_W-1:0] den,
  output logic [vfcl_pkg::DV_Q_W-1:0]   quo
);

  localparam int NW = vfcl_pkg::DV_NUM_W;
  localparam int DW = vfcl_pkg::DV_DEN_W;
  localparam int QW = vfcl_pkg::DV_Q_W;
  localparam int CW = DW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [CW-1:0] dsh;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign dsh = CW'(den_in) << B;
    assign ge  = CW'(rem_in) >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[s] <= den_in;
        if (ge) begin
          rem_q[s] <= rem_in - dsh[NW-1:0];
          quo_q[s] <= quo_in | (QW'(1) << B);
        end else begin
          rem_q[s] <= rem_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

FILE: hdl/vfcl_check.sv
// Port-level checks for volume_far_clamp_cull_lod, bound to the top level.
// Depends on vfcl_pkg for the step count width.
module vfcl_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          draw,
  input logic                          fullscreen,
  input logic [vfcl_pkg::STEP_W-1:0]   step_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(step_count) && $stable(draw))
    else $error("stalled output word changed");

  a_full_draws: assert property (@(posedge clk) disable iff (rst)
    out_valid && fullscreen |-> draw)
    else $error("fullscreen word not drawn");

  a_cull_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !draw |-> step_count == '0 && !fullscreen)
    else $error("culled word carries steps");

  a_min_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && draw && !fullscreen |-> step_count >= vfcl_pkg::STEP_W'(6))
    else $error("billboard word below minimum steps");

endmodule

bind volume_far_clamp_cull_lod vfcl_check u_check (.*);
